FILE: sv/assert_macros.svh
// Assertion macros for the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is low.
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/lmsdb_pkg.sv
// Types, constants and codes shared across the LED matrix scanner.
package lmsdb_pkg;

    localparam int PANEL_WIDTH  = 64;
    localparam int PANEL_HEIGHT = 32;
    localparam int HALF_OFFSET  = 1024;
    localparam int SCAN_COLUMNS = 64;
    localparam int SCAN_ROWS    = 16;
    localparam int BUF_PIXELS   = PANEL_WIDTH * PANEL_HEIGHT;
    localparam int STORE_DEPTH  = 2 * BUF_PIXELS;

    localparam int X_W    = $clog2(PANEL_WIDTH);
    localparam int Y_W    = $clog2(PANEL_HEIGHT);
    localparam int OFF_W  = $clog2(BUF_PIXELS);
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int COL_W  = $clog2(SCAN_COLUMNS);
    localparam int ROW_W  = $clog2(SCAN_ROWS);
    localparam int PIX_W  = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QP_W        = $clog2(QUEUE_DEPTH);

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_SCAN_ENABLE = '0;

    typedef enum logic [2:0] {
        FUNC_DRAW_BACK = 3'd0,
        FUNC_DRAW_ZERO = 3'd1,
        FUNC_CLEAR     = 3'd2,
        FUNC_SWAP      = 3'd3,
        FUNC_SCAN      = 3'd4
    } t_func;

    typedef enum logic [2:0] {
        CMD_DRAW_BACK,
        CMD_DRAW_ZERO,
        CMD_CLEAR,
        CMD_SWAP,
        CMD_SCAN
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind        kind;
        logic [OFF_W-1:0] off;
        logic [PIX_W-1:0] color;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN
    } t_back_state;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row_address;
        logic             latch_row;
        logic             swap_done;
    } t_beat_meta;

endpackage

FILE: sv/lmsdb_if.sv
// Valid/ready channel interfaces for the input items and the column beats.
interface lmsdb_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic [2:0] pixel_color;

    modport source (output valid, func, x_pos, y_pos, pixel_color, input ready);
    modport sink   (input valid, func, x_pos, y_pos, pixel_color, output ready);
endinterface

interface lmsdb_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] column;
    logic [3:0] row_address;
    logic       red_top;
    logic       green_top;
    logic       blue_top;
    logic       red_bottom;
    logic       green_bottom;
    logic       blue_bottom;
    logic       latch_row;
    logic       swap_done;

    modport source (output valid, column, row_address, red_top, green_top, blue_top,
                    red_bottom, green_bottom, blue_bottom, latch_row, swap_done,
                    input ready);
    modport sink   (input valid, column, row_address, red_top, green_top, blue_top,
                    red_bottom, green_bottom, blue_bottom, latch_row, swap_done,
                    output ready);
endinterface

FILE: sv/lmsdb_front.sv
// Front end: accepts input beats, drops the ones with no effect, queues commands.
module lmsdb_front (
    lmsdb_in_if.sink        i_in,
    input  logic            i_scan_enable,
    input  logic            i_accept_en,
    input  logic            i_queue_full,
    output logic            o_push,
    output lmsdb_pkg::t_cmd o_cmd
);

    logic                       in_range;
    logic                       keep;
    logic [lmsdb_pkg::X_W-1:0]  x_lo;
    logic [lmsdb_pkg::Y_W-1:0]  y_lo;

    assign i_in.ready = i_accept_en && !i_queue_full;

    assign x_lo = i_in.x_pos[lmsdb_pkg::X_W-1:0];
    assign y_lo = i_in.y_pos[lmsdb_pkg::Y_W-1:0];

    assign in_range = ({1'b0, i_in.x_pos} < 9'(lmsdb_pkg::PANEL_WIDTH)) &&
                      ({1'b0, i_in.y_pos} < 9'(lmsdb_pkg::PANEL_HEIGHT));

    always_comb begin
        keep        = 1'b0;
        o_cmd.kind  = lmsdb_pkg::CMD_SWAP;
        o_cmd.off   = lmsdb_pkg::OFF_W'(lmsdb_pkg::OFF_W'(y_lo) *
                      lmsdb_pkg::OFF_W'(lmsdb_pkg::PANEL_WIDTH)) +
                      lmsdb_pkg::OFF_W'(x_lo);
        o_cmd.color = i_in.pixel_color;
        unique case (i_in.func)
            lmsdb_pkg::FUNC_DRAW_BACK: begin
                o_cmd.kind = lmsdb_pkg::CMD_DRAW_BACK;
                keep       = in_range;
            end
            lmsdb_pkg::FUNC_DRAW_ZERO: begin
                o_cmd.kind = lmsdb_pkg::CMD_DRAW_ZERO;
                keep       = in_range;
            end
            lmsdb_pkg::FUNC_CLEAR: begin
                o_cmd.kind = lmsdb_pkg::CMD_CLEAR;
                keep       = 1'b1;
            end
            lmsdb_pkg::FUNC_SWAP: begin
                o_cmd.kind = lmsdb_pkg::CMD_SWAP;
                keep       = 1'b1;
            end
            lmsdb_pkg::FUNC_SCAN: begin
                // a disabled scan leaves no trace
                o_cmd.kind = lmsdb_pkg::CMD_SCAN;
                keep       = i_scan_enable;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_push = i_in.valid && i_in.ready && keep;

endmodule

FILE: sv/lmsdb_cmd_fifo.sv
// Short command queue between the front and back ends.
module lmsdb_cmd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lmsdb_pkg::t_cmd i_cmd,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output lmsdb_pkg::t_cmd o_cmd
);

    lmsdb_pkg::t_cmd             r_mem [lmsdb_pkg::QUEUE_DEPTH];
    logic [lmsdb_pkg::QP_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [lmsdb_pkg::QP_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [lmsdb_pkg::QP_W:0]    r_count, n_count;
    logic                        do_pop;

    assign o_full  = (r_count == (lmsdb_pkg::QP_W+1)'(lmsdb_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + (lmsdb_pkg::QP_W+1)'(i_push)
                           - (lmsdb_pkg::QP_W+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

FILE: sv/lmsdb_back.sv
// Back end: frame store, clearing sweeps, buffer swap and row scan pipeline.
module lmsdb_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  lmsdb_pkg::t_cmd i_cmd,
    output logic            o_cmd_pop,
    output logic            o_init_done,
    lmsdb_out_if.source     o_out
);

    localparam int OFF_W  = lmsdb_pkg::OFF_W;
    localparam int ADDR_W = lmsdb_pkg::ADDR_W;
    localparam int COL_W  = lmsdb_pkg::COL_W;
    localparam int ROW_W  = lmsdb_pkg::ROW_W;
    localparam int PIX_W  = lmsdb_pkg::PIX_W;

    lmsdb_pkg::t_back_state r_state, n_state;

    logic [PIX_W-1:0]  r_mem [lmsdb_pkg::STORE_DEPTH];

    logic [ADDR_W-1:0] r_cnt, n_cnt;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic              r_back_is_zero, n_back_is_zero;
    logic              r_swap_pending, n_swap_pending;
    logic              r_rd_vld, n_rd_vld;
    logic              r_out_valid, n_out_valid;

    logic [PIX_W-1:0]  r_rd_top, r_rd_bot;
    lmsdb_pkg::t_beat_meta r_s1_meta, n_s1_meta;
    lmsdb_pkg::t_beat_meta r_out_meta;
    logic [PIX_W-1:0]  r_out_top, r_out_bot;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [PIX_W-1:0]  wdata;
    logic              out_free;
    logic              issue;
    logic              move;
    logic              last_col;
    logic              row_wrap;
    logic [OFF_W-1:0]  top_off;
    logic [OFF_W-1:0]  bot_off;
    logic [ADDR_W-1:0] raddr_top;
    logic [ADDR_W-1:0] raddr_bot;

    assign out_free = !r_out_valid || o_out.ready;
    assign move     = r_rd_vld && out_free;
    assign issue    = (r_state == lmsdb_pkg::ST_SCAN) && (!r_rd_vld || out_free);
    assign last_col = (r_col == COL_W'(lmsdb_pkg::SCAN_COLUMNS - 1));
    assign row_wrap = (r_row == ROW_W'(lmsdb_pkg::SCAN_ROWS - 1));

    // bottom half sits a fixed offset further on and stays inside the buffer
    assign top_off   = OFF_W'(OFF_W'(r_row) * OFF_W'(lmsdb_pkg::PANEL_WIDTH)) + OFF_W'(r_col);
    assign bot_off   = top_off + OFF_W'(lmsdb_pkg::HALF_OFFSET);
    assign raddr_top = {r_back_is_zero, top_off};
    assign raddr_bot = {r_back_is_zero, bot_off};

    assign o_init_done = (r_state != lmsdb_pkg::ST_INIT);

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        n_col          = r_col;
        n_row          = r_row;
        n_back_is_zero = r_back_is_zero;
        n_swap_pending = r_swap_pending;
        o_cmd_pop      = 1'b0;
        we             = 1'b0;
        waddr          = {!r_back_is_zero, i_cmd.off};
        wdata          = i_cmd.color;

        n_s1_meta.column      = r_col;
        n_s1_meta.row_address = r_row;
        n_s1_meta.latch_row   = last_col;
        n_s1_meta.swap_done   = !r_swap_pending;

        unique case (r_state)
            lmsdb_pkg::ST_INIT: begin
                we    = 1'b1;
                waddr = r_cnt;
                wdata = '0;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == ADDR_W'(lmsdb_pkg::STORE_DEPTH - 1)) begin
                    n_state = lmsdb_pkg::ST_IDLE;
                end
            end
            lmsdb_pkg::ST_IDLE: begin
                o_cmd_pop = i_cmd_valid;
                if (i_cmd_valid) begin
                    unique case (i_cmd.kind)
                        lmsdb_pkg::CMD_DRAW_BACK: begin
                            we = 1'b1;
                        end
                        lmsdb_pkg::CMD_DRAW_ZERO: begin
                            we    = 1'b1;
                            waddr = {1'b0, i_cmd.off};
                        end
                        lmsdb_pkg::CMD_CLEAR: begin
                            n_cnt   = '0;
                            n_state = lmsdb_pkg::ST_CLEAR;
                        end
                        lmsdb_pkg::CMD_SWAP: begin
                            n_swap_pending = 1'b1;
                        end
                        lmsdb_pkg::CMD_SCAN: begin
                            n_col   = '0;
                            n_state = lmsdb_pkg::ST_SCAN;
                        end
                        default: begin
                            n_state = r_state;
                        end
                    endcase
                end
            end
            lmsdb_pkg::ST_CLEAR: begin
                we    = 1'b1;
                waddr = {!r_back_is_zero, r_cnt[OFF_W-1:0]};
                wdata = '0;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt[OFF_W-1:0] == OFF_W'(lmsdb_pkg::BUF_PIXELS - 1)) begin
                    n_state = lmsdb_pkg::ST_IDLE;
                end
            end
            lmsdb_pkg::ST_SCAN: begin
                if (issue) begin
                    n_col = r_col + 1'b1;
                    if (last_col) begin
                        // advance the row; swap buffers on wrap if one is pending
                        n_s1_meta.swap_done = !r_swap_pending || row_wrap;
                        n_row = r_row + 1'b1;
                        if (row_wrap && r_swap_pending) begin
                            n_back_is_zero = !r_back_is_zero;
                            n_swap_pending = 1'b0;
                        end
                        n_state = lmsdb_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = lmsdb_pkg::ST_IDLE;
            end
        endcase

        if (issue) begin
            n_rd_vld = 1'b1;
        end else if (move) begin
            n_rd_vld = 1'b0;
        end else begin
            n_rd_vld = r_rd_vld;
        end

        if (move) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= lmsdb_pkg::ST_INIT;
            r_cnt          <= '0;
            r_col          <= '0;
            r_row          <= '0;
            r_back_is_zero <= 1'b0;
            r_swap_pending <= 1'b0;
            r_rd_vld       <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_cnt          <= n_cnt;
            r_col          <= n_col;
            r_row          <= n_row;
            r_back_is_zero <= n_back_is_zero;
            r_swap_pending <= n_swap_pending;
            r_rd_vld       <= n_rd_vld;
            r_out_valid    <= n_out_valid;
        end
    end

    // frame store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (issue) begin
            r_rd_top <= r_mem[raddr_top];
            r_rd_bot <= r_mem[raddr_bot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_meta <= n_s1_meta;
        end
        if (move) begin
            r_out_meta <= r_s1_meta;
            r_out_top  <= r_rd_top;
            r_out_bot  <= r_rd_bot;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.column       = r_out_meta.column;
    assign o_out.row_address  = r_out_meta.row_address;
    assign o_out.red_top      = r_out_top[0];
    assign o_out.green_top    = r_out_top[1];
    assign o_out.blue_top     = r_out_top[2];
    assign o_out.red_bottom   = r_out_bot[0];
    assign o_out.green_bottom = r_out_bot[1];
    assign o_out.blue_bottom  = r_out_bot[2];
    assign o_out.latch_row    = r_out_meta.latch_row;
    assign o_out.swap_done    = r_out_meta.swap_done;

endmodule

FILE: sv/led_matrix_scan_double_buffer.sv
// Top level of the double-buffered LED matrix row scanner.
//
//   channel | dir | handshake          | payload
//   i_in    | in  | valid / ready      | func, x_pos, y_pos, pixel_color
//   o_out   | out | valid / ready      | column, row_address, RGB top/bottom,
//           |     |                    | latch_row, swap_done
//   apb     | in  | psel, penable      | paddr, pwdata, prdata (scan_enable)
//
// A scan shifts out one row of 64 column beats, one column beat a cycle while the output
// is not stalled, from the store's two read ports through the read and output registers.
// Draw and swap commands are handled as they leave the queue; a clear sweeps the back buffer.
// After reset a clearing pass over both buffers runs before any input beat is taken.
// A stalled output holds the scan; the four-entry queue keeps taking beats until it is full.
module led_matrix_scan_double_buffer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    lmsdb_in_if.sink                        i_in,
    lmsdb_out_if.source                     o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lmsdb_pkg::PADDR_W-1:0]   paddr,
    input  logic [lmsdb_pkg::PDATA_W-1:0]   pwdata,
    output logic [lmsdb_pkg::PDATA_W-1:0]   prdata,
    output logic                            pready
);

    logic                        r_scan_enable;
    logic                        cfg_wr;
    logic [lmsdb_pkg::PADDR_W-3:0] reg_idx;
    logic                        push;
    lmsdb_pkg::t_cmd             push_cmd;
    logic                        queue_full;
    logic                        queue_valid;
    lmsdb_pkg::t_cmd             queue_cmd;
    logic                        pop;
    logic                        init_done;

    assign pready  = 1'b1;
    assign reg_idx = paddr[lmsdb_pkg::PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_enable <= 1'b0;
        end else if (cfg_wr && (reg_idx == lmsdb_pkg::REG_SCAN_ENABLE)) begin
            r_scan_enable <= pwdata[0];
        end
    end

    assign prdata = (reg_idx == lmsdb_pkg::REG_SCAN_ENABLE) ?
                    {{(lmsdb_pkg::PDATA_W-1){1'b0}}, r_scan_enable} : '0;

    lmsdb_front u_front (
        .i_in          (i_in),
        .i_scan_enable (r_scan_enable),
        .i_accept_en   (init_done),
        .i_queue_full  (queue_full),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    lmsdb_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd)
    );

    lmsdb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_valid),
        .i_cmd       (queue_cmd),
        .o_cmd_pop   (pop),
        .o_init_done (init_done),
        .o_out       (o_out)
    );

endmodule

FILE: sv/lmsdb_checker.sv
// Port-level assertions for the LED matrix scanner, bound to the top level.
`include "assert_macros.svh"

module lmsdb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [5:0] i_column,
    input logic [3:0] i_row_address,
    input logic       i_latch_row
);

    localparam logic [5:0] LastCol = 6'(lmsdb_pkg::SCAN_COLUMNS - 1);

    // a stalled beat holds its place in the scan
    `ASSERT_CLKD(a_out_hold, i_clk, i_rst_n, i_valid && !i_ready |=> i_valid && $stable(i_column) && $stable(i_row_address), "stalled column beat changed")
    // the latch strobe marks exactly the last column
    `ASSERT_CLKD(a_latch_last, i_clk, i_rst_n, i_valid |-> (i_latch_row == (i_column == LastCol)), "latch strobe not on last column")
    // reset empties the output register
    `ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !i_valid, "output valid after reset")

endmodule

bind led_matrix_scan_double_buffer lmsdb_checker u_lmsdb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_out.valid),
    .i_ready       (o_out.ready),
    .i_column      (o_out.column),
    .i_row_address (o_out.row_address),
    .i_latch_row   (o_out.latch_row)
);

FILE: verif/lmsdb_scan_checker.sv
// Checker for the LED matrix scanner: tracks the frame store and compares every column beat.
module lmsdb_scan_checker
    import lmsdb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    lmsdb_in_if                  i_in_mon,
    lmsdb_out_if                 i_out_mon,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic                 pready,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output int                   o_fail_count,
    output int                   o_beats_due,
    output int                   o_items_seen,
    output int                   o_beats_seen,
    output int                   o_swaps_seen
);

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row_address;
        logic [PIX_W-1:0] top_rgb;
        logic [PIX_W-1:0] bottom_rgb;
        logic             latch_row;
        logic             swap_done;
    } col_beat_t;

    logic [PIX_W-1:0] pixels [STORE_DEPTH];
    logic             back_is_zero;
    logic             swap_pending;
    logic             scan_en;
    logic [ROW_W-1:0] scan_row;
    col_beat_t        beats_due [$];

    initial begin
        o_fail_count = 0;
        o_beats_due  = 0;
        o_items_seen = 0;
        o_beats_seen = 0;
        o_swaps_seen = 0;
    end

    function automatic logic [PIX_W-1:0] shown_pixel(int unsigned off);
        // Offsets past the displayed buffer read as dark
        if (off >= BUF_PIXELS)
            return '0;
        return pixels[(back_is_zero ? BUF_PIXELS : 0) + off];
    endfunction

    function automatic void plot(int unsigned base, logic [7:0] x, logic [7:0] y,
                                 logic [PIX_W-1:0] color);
        if (x < PANEL_WIDTH && y < PANEL_HEIGHT)
            pixels[base + x + PANEL_WIDTH * y] = color;
    endfunction

    function automatic void shift_out_row();
        col_beat_t   b;
        logic        done_before;
        int unsigned top_off;
        done_before = !swap_pending;
        for (int i = 0; i < SCAN_COLUMNS; i++) begin
            top_off       = scan_row * PANEL_WIDTH + i;
            b.column      = COL_W'(i);
            b.row_address = scan_row;
            b.top_rgb     = shown_pixel(top_off);
            b.bottom_rgb  = shown_pixel(HALF_OFFSET + top_off);
            b.latch_row   = (i == SCAN_COLUMNS - 1);
            b.swap_done   = done_before;
            if (i < SCAN_COLUMNS - 1)
                beats_due.push_back(b);
        end
        // Advance the row; a pending swap takes effect on the wrap
        scan_row = scan_row + 1'b1;
        if (scan_row == '0 && swap_pending) begin
            back_is_zero = !back_is_zero;
            swap_pending = 1'b0;
            o_swaps_seen++;
        end
        b.swap_done = !swap_pending;
        beats_due.push_back(b);
    endfunction

    function automatic void apply_item(logic [2:0] func, logic [7:0] x, logic [7:0] y,
                                       logic [PIX_W-1:0] color);
        int unsigned back_base;
        back_base = back_is_zero ? 0 : BUF_PIXELS;
        case (func)
            FUNC_DRAW_BACK: plot(back_base, x, y, color);
            FUNC_DRAW_ZERO: plot(0, x, y, color);
            FUNC_CLEAR: begin
                for (int i = 0; i < BUF_PIXELS; i++)
                    pixels[back_base + i] = '0;
            end
            FUNC_SWAP: swap_pending = 1'b1;
            FUNC_SCAN: begin
                if (scan_en)
                    shift_out_row();
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        col_beat_t want;
        if (!i_rst_n) begin
            for (int i = 0; i < STORE_DEPTH; i++)
                pixels[i] = '0;
            back_is_zero = 1'b0;
            swap_pending = 1'b0;
            scan_en      = 1'b0;
            scan_row     = '0;
            beats_due.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_SCAN_ENABLE)
                scan_en = pwdata[0];
            if (i_out_mon.valid && i_out_mon.ready) begin
                o_beats_seen++;
                if (beats_due.size() == 0) begin
                    $error("column beat %0d arrived with nothing expected", i_out_mon.column);
                    o_fail_count++;
                end else begin
                    want = beats_due.pop_front();
                    check_field("column", want.column, i_out_mon.column);
                    check_field("row_address", want.row_address, i_out_mon.row_address);
                    check_field("red_top", want.top_rgb[0], i_out_mon.red_top);
                    check_field("green_top", want.top_rgb[1], i_out_mon.green_top);
                    check_field("blue_top", want.top_rgb[2], i_out_mon.blue_top);
                    check_field("red_bottom", want.bottom_rgb[0], i_out_mon.red_bottom);
                    check_field("green_bottom", want.bottom_rgb[1], i_out_mon.green_bottom);
                    check_field("blue_bottom", want.bottom_rgb[2], i_out_mon.blue_bottom);
                    check_field("latch_row", want.latch_row, i_out_mon.latch_row);
                    check_field("swap_done", want.swap_done, i_out_mon.swap_done);
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                o_items_seen++;
                apply_item(i_in_mon.func, i_in_mon.x_pos, i_in_mon.y_pos,
                           i_in_mon.pixel_color);
            end
        end
        o_beats_due = beats_due.size();
    end

endmodule

FILE: verif/tb_led_matrix_scan_double_buffer.sv
// Testbench top for the LED matrix scanner: clock, reset, stimulus, pacing and verdict.
module tb_led_matrix_scan_double_buffer;
    import lmsdb_pkg::*;

    // Longest quiet spell a config write must allow: a full queue of clears plus one running
    localparam int SETTLE_CYCLES = 5 * BUF_PIXELS + 256;
    localparam int DRAIN_CYCLES  = 200;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int fail_count;
    int beats_due;
    int items_seen;
    int beats_seen;
    int swaps_seen;

    int in_left;
    bit in_quiet;

    lmsdb_in_if  in_bus ();
    lmsdb_out_if out_bus ();

    led_matrix_scan_double_buffer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    lmsdb_scan_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_bus),
        .i_out_mon    (out_bus),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .o_fail_count (fail_count),
        .o_beats_due  (beats_due),
        .o_items_seen (items_seen),
        .o_beats_seen (beats_seen),
        .o_swaps_seen (swaps_seen)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #24000000;
        $display("TEST FAILED");
        $finish;
    end

    // Pace the column beats: random stalls, with stretches of none
    initial begin : out_pacing
        int  gap;
        int  left;
        bit  quiet;
        left = 0;
        quiet = 1'b0;
        out_bus.ready = 1'b0;
        forever begin
            if (left == 0) begin
                quiet = ($urandom_range(0, 3) == 0);
                left  = $urandom_range(20, 80);
            end
            left--;
            gap = quiet ? 0 : $urandom_range(0, 15);
            repeat (gap) begin
                @(negedge i_clk);
                out_bus.ready <= 1'b0;
            end
            @(negedge i_clk);
            out_bus.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_bus.valid)
                @(posedge i_clk);
        end
    end

    task automatic send_item(logic [2:0] func, logic [7:0] x, logic [7:0] y, logic [2:0] color);
        int gap;
        if (in_left == 0) begin
            in_quiet = ($urandom_range(0, 3) == 0);
            in_left  = $urandom_range(15, 60);
        end
        in_left--;
        gap = in_quiet ? 0 : $urandom_range(0, 15);
        repeat (gap) begin
            @(negedge i_clk);
            in_bus.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_bus.valid       <= 1'b1;
        in_bus.func        <= func;
        in_bus.x_pos       <= x;
        in_bus.y_pos       <= y;
        in_bus.pixel_color <= color;
        @(posedge i_clk);
        while (!in_bus.ready)
            @(posedge i_clk);
    endtask

    // Weighted mix: mostly scans and draws so swaps and row wraps come round often
    task automatic send_random_item();
        int          pick;
        logic [2:0]  func;
        logic [7:0]  x;
        logic [7:0]  y;
        pick = $urandom_range(0, 99);
        x    = 8'($urandom_range(0, 255));
        y    = 8'($urandom_range(0, 255));
        if (pick < 45)
            func = FUNC_SCAN;
        else if (pick < 67)
            func = FUNC_DRAW_BACK;
        else if (pick < 80)
            func = FUNC_DRAW_ZERO;
        else if (pick < 89)
            func = FUNC_SWAP;
        else if (pick < 92)
            func = FUNC_CLEAR;
        else
            func = FUNC_SCAN + 3'($urandom_range(1, 3));
        // Keep most draws on the panel
        if ((func == FUNC_DRAW_BACK || func == FUNC_DRAW_ZERO) && $urandom_range(0, 4) != 0) begin
            x = 8'($urandom_range(0, PANEL_WIDTH - 1));
            y = 8'($urandom_range(0, PANEL_HEIGHT - 1));
        end
        send_item(func, x, y, 3'($urandom_range(0, 7)));
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (beats_due != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_scan_enable(logic value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_SCAN_ENABLE, 2'b00};
        pwdata  <= PDATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        in_left  = 0;
        in_quiet = 1'b0;
        i_rst_n  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        in_bus.valid       = 1'b0;
        in_bus.func        = FUNC_DRAW_BACK;
        in_bus.x_pos       = '0;
        in_bus.y_pos       = '0;
        in_bus.pixel_color = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Scanning is off after reset: two draws, then scans and unused codes that give nothing
        send_item(FUNC_DRAW_BACK, 8'd0, 8'd0, 3'd7);
        send_item(FUNC_DRAW_ZERO, 8'(PANEL_WIDTH - 1), 8'(PANEL_HEIGHT - 1), 3'd7);
        send_item(FUNC_SCAN, 8'd255, 8'd255, 3'd7);
        send_item(FUNC_SCAN + 3'd1, 8'd1, 8'd1, 3'd1);
        send_item(FUNC_SCAN + 3'd2, 8'd2, 8'd2, 3'd2);
        send_item(FUNC_SCAN + 3'd3, 8'd3, 8'd3, 3'd3);
        wait_idle();
        write_scan_enable(1'b1);

        // Edges of the panel, off-panel draws, both halves, swap and clear
        send_item(FUNC_DRAW_BACK, 8'(PANEL_WIDTH - 1), 8'd0, 3'd5);
        send_item(FUNC_DRAW_BACK, 8'(PANEL_WIDTH), 8'd0, 3'd7);
        send_item(FUNC_DRAW_BACK, 8'd0, 8'(PANEL_HEIGHT), 3'd7);
        send_item(FUNC_DRAW_BACK, 8'd255, 8'd255, 3'd2);
        send_item(FUNC_DRAW_ZERO, 8'd0, 8'(PANEL_HEIGHT / 2), 3'd1);
        send_item(FUNC_DRAW_ZERO, 8'(PANEL_WIDTH - 1), 8'd0, 3'd6);
        send_item(FUNC_DRAW_ZERO, 8'd1, 8'd0, 3'd0);
        send_item(FUNC_SCAN, 8'd0, 8'd0, 3'd0);
        send_item(FUNC_SCAN, 8'd0, 8'd0, 3'd0);
        send_item(FUNC_SWAP, 8'd0, 8'd0, 3'd0);
        send_item(FUNC_SWAP, 8'd0, 8'd0, 3'd0);
        send_item(FUNC_SCAN, 8'd0, 8'd0, 3'd0);
        send_item(FUNC_CLEAR, 8'd0, 8'd0, 3'd0);
        send_item(FUNC_SCAN, 8'd0, 8'd0, 3'd0);
        send_item(FUNC_DRAW_ZERO, 8'd0, 8'd0, 3'd3);
        send_item(FUNC_SCAN, 8'd0, 8'd0, 3'd0);

        repeat (130) send_random_item();
        wait_idle();
        write_scan_enable(1'b0);
        repeat (35) send_random_item();
        wait_idle();
        write_scan_enable(1'b1);
        repeat (120) send_random_item();

        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (beats_due != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d input beats over three scan_enable settings;", items_seen);
        $display("checked %0d column beats, %0d buffer swaps taken.", beats_seen, swaps_seen);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
